@@ rtl/core/mtoe_pkg.sv @@
// ----------------------------------------------------------------------------
// mtoe_pkg: shared constants for the median time offset estimator
// Window size default, threshold constants and field widths.
// ----------------------------------------------------------------------------
package mtoe_pkg;

  localparam int unsigned WindowSizeDef = 200;
  localparam int unsigned MedMin        = 5;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned SampleW = 32;
  localparam int unsigned LimW    = 31;
  localparam int unsigned CountW  = 8;

  localparam logic [LimW-1:0]           LimReset = 31'd4200;
  localparam logic signed [SampleW-1:0] NearHi   = 32'sd300;
  localparam logic signed [SampleW-1:0] NearLo   = -32'sd300;

endpackage

@@ rtl/core/mtoe_ram.sv @@
// ----------------------------------------------------------------------------
// mtoe_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtoe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 200,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/median_time_offset_estimator_unit.sv @@
// ----------------------------------------------------------------------------
// median_time_offset_estimator_unit: median network time offset filter
// Drops repeat peers, keeps a sliding window of offsets, adopts an in-range median.
// ----------------------------------------------------------------------------
// One input word is processed at a time by a small sequencer around two
// block RAMs (peer key table, circular sample window) plus a third RAM that
// keeps the window in sorted order. Each RAM step is a read followed by a
// compare cycle. A word runs through the key search, the search for the
// evicted sample once the window is full, the insertion shift and, when it
// runs, the warning scan; each walks at most N entries, where N is the number
// held (at most WINDOW_SIZE). in_tready is low while a word is in work. The
// median is read directly from the middle of the sorted RAM. After reset the
// block first seeds the window with its zero entry. A finished
// result waits in the output register while the next word can be taken.
module median_time_offset_estimator_unit #(
  parameter int unsigned WINDOW_SIZE = mtoe_pkg::WindowSizeDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [mtoe_pkg::LimW-1:0]  cfg_wr_data,   // largest adoptable median magnitude
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [95:0]                in_tdata,      // [63:0] source_key, [95:64] offset_sample
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [47:0]                out_tdata      // [31:0] time_offset, [32] sample_taken,
                                                    // [33] offset_updated, [34] clock_warning,
                                                    // [42:35] window_count, [47:43] zero
);
  import mtoe_pkg::*;

  localparam int unsigned CW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam logic [CW-1:0] WinFull = CW'(WINDOW_SIZE);
  localparam logic [CW-1:0] WinLast = CW'(WINDOW_SIZE - 1);
  localparam logic [CW-1:0] MedLow  = CW'(MedMin);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_KEY_RD, S_KEY_CK, S_OLD_RD, S_OLD_CK, S_FIND_RD, S_FIND_CK,
    S_UP_RD, S_UP_CK, S_DN_RD, S_DN_CK, S_PLACE, S_MED_RD, S_MED_CK,
    S_NEAR_RD, S_NEAR_CK, S_OUT
  } state_t;

  state_t state_r;

  // control
  logic [CW-1:0]  src_cnt_r;    // keys held
  logic [CW-1:0]  win_cnt_r;    // samples held
  logic [AW-1:0]  old_slot_r;
  logic [CW-1:0]  idx_r;
  logic [CW-1:0]  pos_r;
  logic           dup_r;
  logic           taken_r;
  logic           upd_r;
  logic           warn_r;
  logic           warned_r;
  logic [LimW-1:0] lim_r;
  logic signed [SampleW-1:0] adopt_r;
  logic           out_valid_r;

  // payload
  logic [KeyW-1:0]           key_r;
  logic signed [SampleW-1:0] smp_r;
  logic signed [SampleW-1:0] old_val_r;
  logic [47:0]               out_data_r;

  // RAM ports
  logic               key_we;
  logic [AW-1:0]      key_waddr;
  logic [KeyW-1:0]    key_rdata;
  logic               win_we;
  logic [AW-1:0]      win_waddr;
  logic [SampleW-1:0] win_rdata;
  logic               srt_we;
  logic [AW-1:0]      srt_waddr;
  logic [SampleW-1:0] srt_wdata;
  logic [CW-1:0]      srt_raddr;
  logic [SampleW-1:0] srt_rdata;

  logic signed [SampleW-1:0] srt_val;
  logic signed [SampleW:0]   med_ext;
  logic signed [SampleW:0]   lim_pos;
  logic signed [SampleW:0]   lim_neg;
  logic                      in_range;
  logic                      is_near;
  logic [CW+7:0]             cnt_ext;

  assign srt_val  = $signed(srt_rdata);
  assign med_ext  = {srt_val[SampleW-1], srt_val};
  assign lim_pos  = $signed({2'b00, lim_r});
  assign lim_neg  = -lim_pos;
  assign in_range = (med_ext >= lim_neg) && (med_ext <= lim_pos);
  assign is_near  = (srt_val != '0) && (srt_val > NearLo) && (srt_val < NearHi);
  assign cnt_ext  = {8'd0, win_cnt_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // key table: write the new key at the end of the search
  assign key_we    = (state_r == S_KEY_RD) && (idx_r == src_cnt_r) && !dup_r;
  assign key_waddr = src_cnt_r[AW-1:0];

  // circular window writes: seed, append, or replace the oldest
  always_comb begin
    win_we    = 1'b0;
    win_waddr = '0;
    if (state_r == S_INIT) begin
      win_we = 1'b1;
    end else if (key_we && (win_cnt_r != WinFull)) begin
      win_we    = 1'b1;
      win_waddr = win_cnt_r[AW-1:0];
    end else if (state_r == S_OLD_CK) begin
      win_we    = 1'b1;
      win_waddr = old_slot_r;
    end
  end

  // sorted copy: read address by step, writes for shift and placement
  always_comb begin
    srt_raddr = idx_r;
    unique case (state_r)
      S_UP_RD:  srt_raddr = pos_r + CW'(1);
      S_DN_RD:  srt_raddr = pos_r - CW'(1);
      S_MED_RD: srt_raddr = win_cnt_r >> 1;
      default:  srt_raddr = idx_r;
    endcase
  end

  always_comb begin
    srt_we    = 1'b0;
    srt_waddr = pos_r[AW-1:0];
    srt_wdata = srt_rdata;
    if (state_r == S_INIT) begin
      srt_we    = 1'b1;
      srt_waddr = '0;
      srt_wdata = '0;
    end else if (state_r == S_UP_CK) begin
      srt_we = (srt_val < smp_r);
    end else if (state_r == S_DN_CK) begin
      srt_we = (srt_val > smp_r);
    end else if (state_r == S_PLACE) begin
      srt_we    = 1'b1;
      srt_wdata = smp_r;
    end
  end

  mtoe_ram #(.Width(KeyW), .Depth(WINDOW_SIZE), .AddrW(AW)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (key_rdata)
  );

  mtoe_ram #(.Width(SampleW), .Depth(WINDOW_SIZE), .AddrW(AW)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata ((state_r == S_INIT) ? '0 : smp_r),
    .raddr (old_slot_r),
    .rdata (win_rdata)
  );

  mtoe_ram #(.Width(SampleW), .Depth(WINDOW_SIZE), .AddrW(AW)) u_srt_ram (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (srt_raddr[AW-1:0]),
    .rdata (srt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      src_cnt_r   <= '0;
      win_cnt_r   <= CW'(1);
      old_slot_r  <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      dup_r       <= 1'b0;
      taken_r     <= 1'b0;
      upd_r       <= 1'b0;
      warn_r      <= 1'b0;
      warned_r    <= 1'b0;
      lim_r       <= LimReset;
      adopt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lim_r <= cfg_wr_data;
      end
      // retire the pending result once taken; S_OUT reloads it itself
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_INIT: begin
          state_r <= S_IDLE;
        end

        S_IDLE: begin
          if (in_tvalid) begin
            key_r   <= in_tdata[63:0];
            smp_r   <= $signed(in_tdata[95:64]);
            idx_r   <= '0;
            dup_r   <= (src_cnt_r == WinFull);
            taken_r <= 1'b0;
            upd_r   <= 1'b0;
            warn_r  <= 1'b0;
            state_r <= S_KEY_RD;
          end
        end

        // linear search of the key table
        S_KEY_RD: begin
          if (dup_r) begin
            state_r <= S_OUT;
          end else if (idx_r == src_cnt_r) begin
            src_cnt_r <= src_cnt_r + CW'(1);
            taken_r   <= 1'b1;
            if (win_cnt_r != WinFull) begin
              pos_r     <= win_cnt_r;
              win_cnt_r <= win_cnt_r + CW'(1);
              state_r   <= S_DN_RD;
            end else begin
              state_r <= S_OLD_RD;
            end
          end else begin
            state_r <= S_KEY_CK;
          end
        end

        S_KEY_CK: begin
          if (key_rdata == key_r) begin
            dup_r <= 1'b1;
          end
          idx_r   <= idx_r + CW'(1);
          state_r <= S_KEY_RD;
        end

        // evict the oldest sample
        S_OLD_RD: begin
          state_r <= S_OLD_CK;
        end

        S_OLD_CK: begin
          old_val_r  <= $signed(win_rdata);
          old_slot_r <= (old_slot_r == WinLast[AW-1:0]) ? '0 : old_slot_r + AW'(1);
          idx_r      <= '0;
          state_r    <= S_FIND_RD;
        end

        S_FIND_RD: begin
          state_r <= S_FIND_CK;
        end

        S_FIND_CK: begin
          if (srt_val == old_val_r) begin
            pos_r   <= idx_r;
            state_r <= S_UP_RD;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_FIND_RD;
          end
        end

        // shift smaller neighbors down while the hole moves up
        S_UP_RD: begin
          if (pos_r + CW'(1) >= win_cnt_r) begin
            state_r <= S_DN_RD;
          end else begin
            state_r <= S_UP_CK;
          end
        end

        S_UP_CK: begin
          if (srt_val < smp_r) begin
            pos_r   <= pos_r + CW'(1);
            state_r <= S_UP_RD;
          end else begin
            state_r <= S_DN_RD;
          end
        end

        // shift larger neighbors up while the hole moves down
        S_DN_RD: begin
          if (pos_r == '0) begin
            state_r <= S_PLACE;
          end else begin
            state_r <= S_DN_CK;
          end
        end

        S_DN_CK: begin
          if (srt_val > smp_r) begin
            pos_r   <= pos_r - CW'(1);
            state_r <= S_DN_RD;
          end else begin
            state_r <= S_PLACE;
          end
        end

        S_PLACE: begin
          if ((win_cnt_r >= MedLow) && win_cnt_r[0]) begin
            state_r <= S_MED_RD;
          end else begin
            state_r <= S_OUT;
          end
        end

        S_MED_RD: begin
          state_r <= S_MED_CK;
        end

        S_MED_CK: begin
          upd_r <= 1'b1;
          idx_r <= '0;
          if (in_range) begin
            adopt_r <= srt_val;
            state_r <= S_OUT;
          end else begin
            adopt_r <= '0;
            state_r <= warned_r ? S_OUT : S_NEAR_RD;
          end
        end

        // look for a small nonzero sample before raising the warning
        S_NEAR_RD: begin
          if (idx_r == win_cnt_r) begin
            warn_r   <= 1'b1;
            warned_r <= 1'b1;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_NEAR_CK;
          end
        end

        S_NEAR_CK: begin
          if (is_near) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_NEAR_RD;
          end
        end

        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {5'd0, cnt_ext[7:0], warn_r, upd_r, taken_r, adopt_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
